// ----- rtl/tlvr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlvr_pkg: shared types and constants of the TLV message reader
// Operation and status codes, sequencer states and the structs that pass
// between the sequencer, the shared adder and the top level.
// ----------------------------------------------------------------------------
package tlvr_pkg;

   localparam int TAG_TYPE_W = 8;
   localparam int TAG_LEN_W  = 20;
   localparam int IDX_BITS   = 9;
   localparam int SIZE_CAP   = 256;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_REWIND = 2'd1,
      OP_GET    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_BAD_TYPE = 2'd2,
      ST_OVERRUN = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROOM,
      S_TAG,
      S_NEXT,
      S_READ,
      S_DATA,
      S_PUT
   } state_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  a;
      logic [TAG_LEN_W:0]   b;
      logic [IDX_BITS-1:0]  limit;
   } alu_in_type;

   typedef struct packed {
      logic [TAG_LEN_W+1:0] sum;
      logic                 over;
   } alu_out_type;

   typedef struct packed {
      status_type            status;
      logic [31:0]           payload_word;
      logic [2:0]            bytes_valid;
      logic [IDX_BITS-1:0]   copied_length;
      logic [TAG_TYPE_W-1:0] found_type;
      logic                  last_word;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/tlvr_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlvr_alu: shared add and bound compare
// Adds an index and an offset and flags a sum that runs past the limit.
// ----------------------------------------------------------------------------
module tlvr_alu (
   input  tlvr_pkg::alu_in_type  alu_req,
   output tlvr_pkg::alu_out_type alu_rsp
);
   import tlvr_pkg::*;

   logic [TAG_LEN_W+1:0] sum;

   assign sum          = (TAG_LEN_W+2)'(alu_req.a) + (TAG_LEN_W+2)'(alu_req.b);
   assign alu_rsp.sum  = sum;
   assign alu_rsp.over = sum > (TAG_LEN_W+2)'(alu_req.limit);

endmodule
`default_nettype wire

// ----- rtl/tlvr_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlvr_store: message word memory
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module tlvr_store #(
   parameter int STORE_WORDS = 64,
   localparam int AW = $clog2(STORE_WORDS)
) (
   input  logic          clock,
   input  logic          st_we,
   input  logic [AW-1:0] st_waddr,
   input  logic [31:0]   st_wdata,
   input  logic          st_re,
   input  logic [AW-1:0] st_raddr,
   output logic [31:0]   st_rdata
);

   logic [31:0] mem [STORE_WORDS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (st_we) begin
         mem[st_waddr] <= st_wdata;
      end
      if (st_re) begin
         rdata_ff <= mem[st_raddr];
      end
   end

   assign st_rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/tlvr_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlvr_seq: record reader sequencer
// Walks a get through tag check, bound checks and payload words, driving
// the shared adder and the store, and holds the result word register.
// ----------------------------------------------------------------------------
module tlvr_seq #(
   parameter int STORE_WORDS = 64,
   localparam int AW  = $clog2(STORE_WORDS),
   localparam int IW  = (AW > 7) ? AW : 7,
   localparam int AXW = (AW > 6) ? AW : 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic [5:0]                req_word_address,
   input  logic [31:0]               req_word_value,
   input  logic [7:0]                req_expected_type,
   input  logic [8:0]                req_max_length,
   input  logic [8:0]                size,
   output tlvr_pkg::alu_in_type      alu_req,
   input  tlvr_pkg::alu_out_type     alu_rsp,
   output logic                      st_we,
   output logic [AW-1:0]             st_waddr,
   output logic [31:0]               st_wdata,
   output logic                      st_re,
   output logic [AW-1:0]             st_raddr,
   input  logic [31:0]               st_rdata,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tlvr_pkg::rsp_type         rsp
);
   import tlvr_pkg::*;

   state_type              state_ff, state_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [IDX_BITS-1:0]    base_ff, base_in;
   logic [TAG_TYPE_W-1:0]  exp_ff, exp_in;
   logic [IDX_BITS-1:0]    req_ff, req_in;
   logic [TAG_TYPE_W-1:0]  ftype_ff, ftype_in;
   logic [TAG_LEN_W-1:0]   len_ff, len_in;
   logic [IDX_BITS-1:0]    copied_ff, copied_in;
   logic [IDX_BITS-1:0]    left_ff, left_in;
   logic [6:0]             wptr_ff, wptr_in;
   rsp_type                pend_ff, pend_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   rsp_free;
   logic                   addr_ok;
   logic [AXW-1:0]         waddr_ext;
   logic [IW-1:0]          raddr_ext;
   logic [TAG_LEN_W-1:0]   dlen;
   logic [TAG_TYPE_W-1:0]  dtype;
   logic [2:0]             nvalid;
   logic [31:0]            masked;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign addr_ok   = 32'(req_word_address) < 32'(STORE_WORDS);
   assign waddr_ext = AXW'(req_word_address);
   assign st_waddr  = waddr_ext[AW-1:0];
   assign st_wdata  = req_word_value;
   assign st_raddr  = raddr_ext[AW-1:0];
   assign dlen      = st_rdata[TAG_TYPE_W +: TAG_LEN_W];
   assign dtype     = st_rdata[TAG_TYPE_W-1:0];
   assign nvalid    = (left_ff >= 9'd4) ? 3'd4 : left_ff[2:0];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         masked[8*i +: 8] = (3'(i) < nvalid) ? st_rdata[8*i +: 8] : 8'd0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      req_in       = req_ff;
      ftype_in     = ftype_ff;
      len_in       = len_ff;
      copied_in    = copied_ff;
      left_in      = left_ff;
      wptr_in      = wptr_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      st_we        = 1'b0;
      st_re        = 1'b0;
      raddr_ext    = IW'(idx_ff[IDX_BITS-1:2]);
      alu_req.a     = idx_ff;
      alu_req.b     = (TAG_LEN_W+1)'(4);
      alu_req.limit = size;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (op_type'(req_operation))
                  OP_LOAD:   st_we = addr_ok;
                  OP_REWIND: idx_in = '0;
                  OP_GET: begin
                     exp_in   = req_expected_type;
                     req_in   = (req_max_length > 9'(SIZE_CAP)) ? 9'(SIZE_CAP)
                                                                : req_max_length;
                     state_in = S_ROOM;
                  end
                  default: ;
               endcase
            end
         end
         S_ROOM: begin
            // tag must fit inside the message
            pend_in.status        = ST_NO_ROOM;
            pend_in.payload_word  = '0;
            pend_in.bytes_valid   = '0;
            pend_in.copied_length = '0;
            pend_in.found_type    = '0;
            pend_in.last_word     = 1'b1;
            if (alu_rsp.over) begin
               state_in = S_PUT;
            end else begin
               st_re    = 1'b1;
               base_in  = alu_rsp.sum[IDX_BITS-1:0];
               state_in = S_TAG;
            end
         end
         S_TAG: begin
            alu_req.a = base_ff;
            alu_req.b = {1'b0, dlen};
            ftype_in  = dtype;
            len_in    = dlen;
            copied_in = (dlen < TAG_LEN_W'(req_ff)) ? dlen[IDX_BITS-1:0] : req_ff;
            pend_in.found_type = dtype;
            if (dtype != exp_ff) begin
               pend_in.status = ST_BAD_TYPE;
               state_in       = S_PUT;
            end else if (alu_rsp.over) begin
               // step past the tag only
               idx_in         = base_ff;
               pend_in.status = ST_OVERRUN;
               state_in       = S_PUT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            // advance index past the padded payload
            alu_req.a = base_ff;
            alu_req.b = {1'b0, len_ff} + (TAG_LEN_W+1)'(3);
            idx_in    = {alu_rsp.sum[IDX_BITS-1:2], 2'b00};
            left_in   = copied_ff;
            wptr_in   = base_ff[IDX_BITS-1:2];
            pend_in.status        = ST_OK;
            pend_in.copied_length = copied_ff;
            pend_in.found_type    = ftype_ff;
            if (copied_ff == '0) begin
               state_in = S_PUT;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            st_re     = 1'b1;
            raddr_ext = IW'(wptr_ff);
            state_in  = S_DATA;
         end
         S_DATA: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = ST_OK;
               rsp_in.payload_word  = masked;
               rsp_in.bytes_valid   = nvalid;
               rsp_in.copied_length = copied_ff;
               rsp_in.found_type    = ftype_ff;
               rsp_in.last_word     = (left_ff <= 9'd4);
               left_in              = left_ff - 9'(nvalid);
               wptr_in              = wptr_ff + 7'd1;
               state_in             = (left_ff <= 9'd4) ? S_IDLE : S_READ;
            end
         end
         S_PUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      req_ff    <= req_in;
      ftype_ff  <= ftype_in;
      len_ff    <= len_in;
      copied_ff <= copied_in;
      left_ff   <= left_in;
      wptr_ff   <= wptr_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_idx_aligned: assert property (@(posedge clock) disable iff (reset)
      idx_ff[1:0] == 2'b00)
      else $error("read index lost word alignment");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DATA |-> left_ff != '0)
      else $error("payload word fetched with no bytes left");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_word |-> rsp_ff.bytes_valid == 3'd4)
      else $error("partial word before the last");

   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |->
         rsp_ff.last_word && rsp_ff.payload_word == '0)
      else $error("failed get carries payload or continues");

endmodule
`default_nettype wire

// ----- rtl/tlv_message_reader_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_message_reader_unit: TLV record reader over a message word store
// Loads message words, rewinds the byte index and hands back records.
// ----------------------------------------------------------------------------
// Load and rewind words return nothing.
// A get with payload runs the room check, tag check and index advance, then
// a store read and a result per payload word, and returns to idle. A failed
// get ends after the room check when the tag does not fit and after the tag
// check otherwise, an empty copy after the index advance; result stalls add
// to each. All steps share the single store read port and the one adder.
// Reset clears the sequencer, read index and message size; the store is not
// cleared and holds undefined words until loaded.
// ----------------------------------------------------------------------------
module tlv_message_reader_unit #(
   parameter int STORE_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [5:0]  req_word_address,
   input  logic [31:0] req_word_value,
   input  logic [7:0]  req_expected_type,
   input  logic [8:0]  req_max_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_payload_word,
   output logic [2:0]  rsp_bytes_valid,
   output logic [8:0]  rsp_copied_length,
   output logic [7:0]  rsp_found_type,
   output logic        rsp_last_word,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import tlvr_pkg::*;

   localparam int AW      = $clog2(STORE_WORDS);
   // usable size is bounded by both the index range and the store depth
   localparam int SIZE_LIM = (STORE_WORDS * 4 < SIZE_CAP) ? STORE_WORDS * 4 : SIZE_CAP;

   logic [8:0]   msg_bytes_ff, msg_bytes_in;
   logic [8:0]   size_ff, size_in;
   alu_in_type   alu_req;
   alu_out_type  alu_rsp;
   logic         st_we;
   logic [AW-1:0] st_waddr;
   logic [31:0]  st_wdata;
   logic         st_re;
   logic [AW-1:0] st_raddr;
   logic [31:0]  st_rdata;
   rsp_type      rsp;

   // hold message size; the user must write it only while idle (not enforced here)
   assign msg_bytes_in = csr_wr_en ? csr_wr_data : msg_bytes_ff;
   // clamp to the usable size
   assign size_in      = (msg_bytes_ff > 9'(SIZE_LIM)) ? 9'(SIZE_LIM) : msg_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_bytes_ff <= '0;
         size_ff      <= '0;
      end else begin
         msg_bytes_ff <= msg_bytes_in;
         size_ff      <= size_in;
      end
   end

   tlvr_seq #(
      .STORE_WORDS (STORE_WORDS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_word_address  (req_word_address),
      .req_word_value    (req_word_value),
      .req_expected_type (req_expected_type),
      .req_max_length    (req_max_length),
      .size              (size_ff),
      .alu_req           (alu_req),
      .alu_rsp           (alu_rsp),
      .st_we             (st_we),
      .st_waddr          (st_waddr),
      .st_wdata          (st_wdata),
      .st_re             (st_re),
      .st_raddr          (st_raddr),
      .st_rdata          (st_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp               (rsp)
   );

   tlvr_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   tlvr_store #(
      .STORE_WORDS (STORE_WORDS)
   ) u_store (
      .clock    (clock),
      .st_we    (st_we),
      .st_waddr (st_waddr),
      .st_wdata (st_wdata),
      .st_re    (st_re),
      .st_raddr (st_raddr),
      .st_rdata (st_rdata)
   );

   // drive the result word fields
   assign rsp_status        = rsp.status;
   assign rsp_payload_word  = rsp.payload_word;
   assign rsp_bytes_valid   = rsp.bytes_valid;
   assign rsp_copied_length = rsp.copied_length;
   assign rsp_found_type    = rsp.found_type;
   assign rsp_last_word     = rsp.last_word;

endmodule
`default_nettype wire
